// ===== hw/rtl/pcod_pkg.sv =====
// Shared types, constants and helper functions of the orientation decoder.
package pcod_pkg;

    localparam int MAX_DIM_DEF    = 1024;
    localparam int MEAN_FRAC_DEF  = 8;
    localparam int MEAN_INT_W     = 16;
    localparam int DOT_W          = 16;
    localparam int INTEN_W        = 24;
    localparam int POS_W          = 10;
    localparam int IDX_W          = 2;
    localparam int INT_W          = 44;
    localparam int CNT_W          = 36;
    localparam int NUM_BINS       = 9;
    localparam int BIN_IDX_W      = 4;
    localparam int QUEUE_DEPTH    = 2;

    typedef logic [BIN_IDX_W-1:0] bin_idx_t;

    // One frozen set of bins, handed from the accumulator to the decoder.
    typedef struct packed {
        logic [NUM_BINS-1:0][INT_W-1:0] inten;
        logic [NUM_BINS-1:0][CNT_W-1:0] cnt;
    } bins_t;

    // Queue control from the two sides.
    typedef struct packed {
        logic push;
        logic pop;
    } qctl_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } qstat_t;

    typedef enum logic [1:0] {
        W_ZERO,
        W_POS,
        W_NEG
    } weight_t;

    // Residue mod 3 of a position: 4 is 1 mod 3, so sum the base-4 digits.
    function automatic logic [1:0] mod3(input logic [POS_W-1:0] x);
        logic [3:0] s;
        logic [2:0] t;
        logic [1:0] res;
        s = '0;
        for (int i = 0; i < POS_W / 2; i++)
        begin
            s = s + 4'(x[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]);
        unique case (t)
            3'd0, 3'd3, 3'd6: res = 2'd0;
            3'd1, 3'd4:       res = 2'd1;
            3'd2, 3'd5:       res = 2'd2;
            default:          res = 2'd0;
        endcase
        return res;
    endfunction

    // Weight of grid cell (r, c) in mask (c1, c2, q).
    function automatic weight_t mask_weight(input logic [1:0] c1, input logic [1:0] c2,
                                            input logic [1:0] q, input logic [1:0] r,
                                            input logic [1:0] c);
        logic i;
        logic j;
        logic nr;
        logic nc;
        weight_t w;
        i  = (r == 2'd2) || (r == 2'd1 && c1 == 2'd2);
        j  = (c == 2'd2) || (c == 2'd1 && c2 == 2'd2);
        nr = (q <= 2'd1);
        nc = (q == 2'd0) || (q == 2'd2);
        if (r == c1 || c == c2)
        begin
            w = W_ZERO;
        end
        else if (i == nr && j == nc)
        begin
            w = W_NEG;
        end
        else
        begin
            w = W_POS;
        end
        return w;
    endfunction

endpackage

// ===== hw/rtl/pcod_if.sv =====
// Valid/ready channel interfaces for cells in and decode results out.
interface pcod_in_if;
    logic                          valid;
    logic                          ready;
    logic [pcod_pkg::DOT_W-1:0]    dot_count;
    logic [pcod_pkg::INTEN_W-1:0]  intensity_sum;
    logic [pcod_pkg::POS_W-1:0]    cell_row;
    logic [pcod_pkg::POS_W-1:0]    cell_col;
    logic                          last_cell;

    modport source (output valid, dot_count, intensity_sum, cell_row, cell_col, last_cell,
                    input ready);
    modport sink   (input valid, dot_count, intensity_sum, cell_row, cell_col, last_cell,
                    output ready);
endinterface

interface pcod_out_if;
    logic                      valid;
    logic                      ready;
    logic [pcod_pkg::IDX_W-1:0] code_row;
    logic [pcod_pkg::IDX_W-1:0] code_col;
    logic [pcod_pkg::IDX_W-1:0] missing_row;
    logic [pcod_pkg::IDX_W-1:0] missing_col;
    logic [pcod_pkg::IDX_W-1:0] quadrant;
    logic                      found;
    logic                      empty_bin;

    modport source  (output valid, code_row, code_col, missing_row, missing_col, quadrant,
                     found, empty_bin, input ready);
    modport sink    (input valid, code_row, code_col, missing_row, missing_col, quadrant,
                     found, empty_bin, output ready);
    modport monitor (input valid, ready, code_row, code_col, missing_row, missing_col,
                     quadrant, found, empty_bin);
endinterface

// ===== hw/rtl/pcod_front.sv =====
// Cell intake: bin selection and saturating accumulation, snapshot on last cell.
module pcod_front #(
    parameter int MAX_DIM = pcod_pkg::MAX_DIM_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    pcod_in_if.sink          cells,
    input  pcod_pkg::qstat_t qstat,
    output logic             push,
    output pcod_pkg::bins_t  snap
);

    logic [pcod_pkg::NUM_BINS-1:0][pcod_pkg::INT_W-1:0] int_reg;
    logic [pcod_pkg::NUM_BINS-1:0][pcod_pkg::CNT_W-1:0] cnt_reg;

    logic                       take;
    logic                       in_grid;
    pcod_pkg::bin_idx_t         k;
    logic [pcod_pkg::INT_W:0]   int_sum;
    logic [pcod_pkg::CNT_W:0]   cnt_sum;
    logic [pcod_pkg::INT_W-1:0] int_upd;
    logic [pcod_pkg::CNT_W-1:0] cnt_upd;

    assign cells.ready = !qstat.full;
    assign take        = cells.valid && cells.ready;
    assign in_grid     = (32'(cells.cell_row) < 32'(MAX_DIM)) &&
                         (32'(cells.cell_col) < 32'(MAX_DIM));
    assign k = pcod_pkg::BIN_IDX_W'(pcod_pkg::mod3(cells.cell_row)) * pcod_pkg::BIN_IDX_W'(3)
             + pcod_pkg::BIN_IDX_W'(pcod_pkg::mod3(cells.cell_col));

    // Saturate at all ones instead of wrapping.
    assign int_sum = {1'b0, int_reg[k]} + (pcod_pkg::INT_W+1)'(cells.intensity_sum);
    assign cnt_sum = {1'b0, cnt_reg[k]} + (pcod_pkg::CNT_W+1)'(cells.dot_count);
    assign int_upd = int_sum[pcod_pkg::INT_W] ? '1 : int_sum[pcod_pkg::INT_W-1:0];
    assign cnt_upd = cnt_sum[pcod_pkg::CNT_W] ? '1 : cnt_sum[pcod_pkg::CNT_W-1:0];

    // The snapshot includes the last cell itself.
    always_comb
    begin
        for (int b = 0; b < pcod_pkg::NUM_BINS; b++)
        begin
            if (in_grid && k == pcod_pkg::BIN_IDX_W'(b))
            begin
                snap.inten[b] = int_upd;
                snap.cnt[b]   = cnt_upd;
            end
            else
            begin
                snap.inten[b] = int_reg[b];
                snap.cnt[b]   = cnt_reg[b];
            end
        end
    end

    assign push = take && cells.last_cell;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take)
        begin
            if (cells.last_cell)
            begin
                int_reg <= '0;
                cnt_reg <= '0;
            end
            else if (in_grid)
            begin
                int_reg[k] <= int_upd;
                cnt_reg[k] <= cnt_upd;
            end
        end
    end

endmodule

// ===== hw/rtl/pcod_fifo.sv =====
// Short queue of bin snapshots between intake and decoder.
module pcod_fifo #(
    parameter int DEPTH = pcod_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pcod_pkg::qctl_t  qctl,
    input  pcod_pkg::bins_t  wr_data,
    output pcod_pkg::qstat_t qstat,
    output pcod_pkg::bins_t  rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcod_pkg::bins_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign qstat.full     = (count_reg == CNT_W'(DEPTH));
    assign qstat.nonempty = (count_reg != '0);
    assign rd_data        = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (qctl.push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (qctl.pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (qctl.push && !qctl.pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (qctl.pop && !qctl.push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/pcod_back.sv =====
// Decoder: serial bin means, 36-mask scan, result register.
module pcod_back #(
    parameter int MEAN_FRAC_BITS = pcod_pkg::MEAN_FRAC_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pcod_pkg::qstat_t qstat,
    input  pcod_pkg::bins_t  rd_data,
    output logic             pop,
    pcod_out_if.source       result
);

    localparam int MW     = pcod_pkg::MEAN_INT_W + MEAN_FRAC_BITS;
    localparam int SW     = MW + 3;
    localparam int STEP_W = $clog2(MW + 1);
    localparam int CW     = pcod_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCORE,
        S_FLUSH,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    pcod_pkg::bins_t                 work_reg;
    pcod_pkg::bin_idx_t              bin_reg;
    logic [STEP_W-1:0]               step_reg;
    logic [CW-1:0]                   rem_reg;
    logic [MW-1:0]                   num_reg;
    logic [MW-1:0]                   quo_reg;
    logic [pcod_pkg::NUM_BINS-1:0][MW-1:0] mean_reg;
    logic                            empty_reg;
    logic [1:0]                      c1_reg, c2_reg, q_reg;
    logic signed [SW-1:0]            sc_reg;
    logic                            sc_valid_reg;
    logic [1:0]                      sc1_reg, sc2_reg, scq_reg;
    logic signed [SW-1:0]            best_reg;
    logic [1:0]                      b1_reg, b2_reg, bq_reg;
    logic                            found_reg;
    logic                            out_valid_reg;
    logic [1:0]                      o_row_reg, o_col_reg, o_mrow_reg, o_mcol_reg, o_q_reg;
    logic                            o_found_reg, o_empty_reg;

    logic [CW-1:0]                   cur_cnt;
    logic [pcod_pkg::INT_W-1:0]      cur_int;
    logic                            sat;
    logic [CW:0]                     trial;
    logic                            qbit;
    logic signed [SW-1:0]            score;
    logic [1:0]                      mrow, mcol;
    logic                            last_mask;
    logic                            out_free;

    assign cur_cnt = work_reg.cnt[bin_reg];
    assign cur_int = work_reg.inten[bin_reg];
    // Quotient overflows the mean format exactly when intensity >= count * 2^16.
    assign sat     = {8'd0, cur_int} >= {cur_cnt, 16'd0};
    assign trial   = {rem_reg, num_reg[MW-1]};
    assign qbit    = trial >= {1'b0, cur_cnt};

    always_comb
    begin
        score = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                unique case (pcod_pkg::mask_weight(c1_reg, c2_reg, q_reg, 2'(r), 2'(c)))
                    pcod_pkg::W_POS: score = score + $signed(SW'(mean_reg[r*3+c]));
                    pcod_pkg::W_NEG: score = score - $signed(SW'(mean_reg[r*3+c]));
                    default:         score = score;
                endcase
            end
        end
    end

    always_comb
    begin
        if (bq_reg <= 2'd1)
        begin
            mrow = (b1_reg == 2'd2) ? 2'd1 : 2'd2;
        end
        else
        begin
            mrow = (b1_reg == 2'd0) ? 2'd1 : 2'd0;
        end
        if (bq_reg == 2'd0 || bq_reg == 2'd2)
        begin
            mcol = (b2_reg == 2'd2) ? 2'd1 : 2'd2;
        end
        else
        begin
            mcol = (b2_reg == 2'd0) ? 2'd1 : 2'd0;
        end
    end

    assign last_mask = (c1_reg == 2'd2) && (c2_reg == 2'd2) && (q_reg == 2'd3);
    assign out_free  = !out_valid_reg || result.ready;
    assign pop       = (state_reg == S_IDLE) && qstat.nonempty;

    assign result.valid       = out_valid_reg;
    assign result.code_row    = o_row_reg;
    assign result.code_col    = o_col_reg;
    assign result.missing_row = o_mrow_reg;
    assign result.missing_col = o_mcol_reg;
    assign result.quadrant    = o_q_reg;
    assign result.found       = o_found_reg;
    assign result.empty_bin   = o_empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            work_reg      <= '0;
            bin_reg       <= '0;
            step_reg      <= '0;
            rem_reg       <= '0;
            num_reg       <= '0;
            quo_reg       <= '0;
            mean_reg      <= '0;
            empty_reg     <= 1'b0;
            c1_reg        <= '0;
            c2_reg        <= '0;
            q_reg         <= '0;
            sc_reg        <= '0;
            sc_valid_reg  <= 1'b0;
            sc1_reg       <= '0;
            sc2_reg       <= '0;
            scq_reg       <= '0;
            best_reg      <= '0;
            b1_reg        <= '0;
            b2_reg        <= '0;
            bq_reg        <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            o_row_reg     <= '0;
            o_col_reg     <= '0;
            o_mrow_reg    <= '0;
            o_mcol_reg    <= '0;
            o_q_reg       <= '0;
            o_found_reg   <= 1'b0;
            o_empty_reg   <= 1'b0;
        end
        else
        begin
            // Raise valid when a result loads, drop it after the transfer.
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Compare stage of the scan.
            sc_valid_reg <= (state_reg == S_SCORE);
            if (sc_valid_reg && sc_reg > best_reg)
            begin
                best_reg  <= sc_reg;
                b1_reg    <= sc1_reg;
                b2_reg    <= sc2_reg;
                bq_reg    <= scq_reg;
                found_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (qstat.nonempty)
                    begin
                        work_reg  <= rd_data;
                        empty_reg <= 1'b0;
                        bin_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        if (cur_cnt == '0 || sat)
                        begin
                            mean_reg[bin_reg] <= (cur_cnt == '0) ? '0 : '1;
                            if (cur_cnt == '0)
                            begin
                                empty_reg <= 1'b1;
                            end
                            if (bin_reg == pcod_pkg::BIN_IDX_W'(pcod_pkg::NUM_BINS - 1))
                            begin
                                state_reg <= S_SCORE;
                            end
                            bin_reg <= bin_reg + 1'b1;
                        end
                        else
                        begin
                            // Remainder starts with the bits above the quotient window.
                            rem_reg  <= CW'(cur_int >> 16);
                            num_reg  <= MW'(cur_int[15:0]) << MEAN_FRAC_BITS;
                            quo_reg  <= '0;
                            step_reg <= STEP_W'(1);
                        end
                    end
                    else
                    begin
                        rem_reg <= qbit ? CW'(trial - {1'b0, cur_cnt}) : CW'(trial);
                        num_reg <= num_reg << 1;
                        quo_reg <= {quo_reg[MW-2:0], qbit};
                        if (step_reg == STEP_W'(MW))
                        begin
                            mean_reg[bin_reg] <= {quo_reg[MW-2:0], qbit};
                            step_reg          <= '0;
                            bin_reg           <= bin_reg + 1'b1;
                            if (bin_reg == pcod_pkg::BIN_IDX_W'(pcod_pkg::NUM_BINS - 1))
                            begin
                                state_reg <= S_SCORE;
                            end
                        end
                        else
                        begin
                            step_reg <= step_reg + 1'b1;
                        end
                    end
                    c1_reg    <= '0;
                    c2_reg    <= '0;
                    q_reg     <= '0;
                    best_reg  <= '0;
                    b1_reg    <= '0;
                    b2_reg    <= '0;
                    bq_reg    <= '0;
                    found_reg <= 1'b0;
                end
                S_SCORE:
                begin
                    sc_reg       <= score;
                    sc1_reg      <= c1_reg;
                    sc2_reg      <= c2_reg;
                    scq_reg      <= q_reg;
                    q_reg        <= q_reg + 1'b1;
                    if (q_reg == 2'd3)
                    begin
                        if (c2_reg == 2'd2)
                        begin
                            c2_reg <= '0;
                            c1_reg <= c1_reg + 1'b1;
                        end
                        else
                        begin
                            c2_reg <= c2_reg + 1'b1;
                        end
                    end
                    if (last_mask)
                    begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        o_row_reg     <= b1_reg;
                        o_col_reg     <= b2_reg;
                        o_mrow_reg    <= mrow;
                        o_mcol_reg    <= mcol;
                        o_q_reg       <= bq_reg;
                        o_found_reg   <= found_reg;
                        o_empty_reg   <= empty_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/periodic_cell_orientation_decoder_unit.sv =====
// Top level of the periodic cell orientation decoder.
//
// Cells stream in at one transfer per clock. Each cell is added into one of nine
// saturating bins picked by (row mod 3, column mod 3); cells at or beyond MAX_DIM
// in row or column are skipped. A cell marked last freezes the bins into a
// two-entry queue and clears them, so intake goes on while the decoder works.
// Intake stalls only when both queue entries hold thumbnails not yet decoded.
// The decoder takes each snapshot in turn: a shared one-bit-per-cycle divider
// forms the nine means in unsigned Q16.MEAN_FRAC_BITS (an empty bin gets zero and
// a saturated bin all ones, without a division), then scores the 36 masks one
// per cycle, then loads the result register. A result waiting on the output
// holds the decoder but does not block intake until the queue fills.
module periodic_cell_orientation_decoder_unit #(
    parameter int MAX_DIM        = pcod_pkg::MAX_DIM_DEF,
    parameter int MEAN_FRAC_BITS = pcod_pkg::MEAN_FRAC_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    pcod_in_if.sink    cells,
    pcod_out_if.source result
);

    pcod_pkg::qctl_t  qctl;
    pcod_pkg::qstat_t qstat;
    pcod_pkg::bins_t  snap;
    pcod_pkg::bins_t  rd_data;
    logic             push;
    logic             pop;

    // Accumulate cells and hand over a snapshot on each last cell.
    pcod_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cells (cells),
        .qstat (qstat),
        .push  (push),
        .snap  (snap)
    );

    assign qctl.push = push;
    assign qctl.pop  = pop;

    // Hold snapshots between the two sides.
    pcod_fifo #(
        .DEPTH (pcod_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .qctl    (qctl),
        .wr_data (snap),
        .qstat   (qstat),
        .rd_data (rd_data)
    );

    // Decode one snapshot at a time into the result register.
    pcod_back #(
        .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .rd_data (rd_data),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== hw/rtl/pcod_checker.sv =====
// Port-level checks on the decoder result channel, bound to the top level.
module pcod_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         valid,
    input logic                         ready,
    input logic [pcod_pkg::IDX_W-1:0]   code_row,
    input logic [pcod_pkg::IDX_W-1:0]   code_col,
    input logic [pcod_pkg::IDX_W-1:0]   missing_row,
    input logic [pcod_pkg::IDX_W-1:0]   missing_col,
    input logic [pcod_pkg::IDX_W-1:0]   quadrant,
    input logic                         found
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("result dropped before transfer");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> code_row != 2'd3 && code_col != 2'd3 &&
                  missing_row != 2'd3 && missing_col != 2'd3)
        else $error("index out of range");

    a_defaults: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !found |-> code_row == 2'd0 && code_col == 2'd0 &&
            quadrant == 2'd0 && missing_row == 2'd2 && missing_col == 2'd2)
        else $error("wrong defaults without a winner");

    a_missing_differs: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> missing_row != code_row && missing_col != code_col)
        else $error("missing index equals coding index");

endmodule

bind periodic_cell_orientation_decoder_unit pcod_checker u_pcod_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (result.valid),
    .ready       (result.ready),
    .code_row    (result.code_row),
    .code_col    (result.code_col),
    .missing_row (result.missing_row),
    .missing_col (result.missing_col),
    .quadrant    (result.quadrant),
    .found       (result.found)
);
